### hdl/mrrs_pkg.sv
`timescale 1ns / 1ps
package mrrs_pkg;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned PidW    = 4;
  localparam int unsigned StatW   = 2;
  localparam int unsigned LevelW  = 2;
  localparam int unsigned ResW    = 3;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK      = 3'd0,
    FUNC_SET_STAT  = 3'd1,
    FUNC_ADMIT     = 3'd2,
    FUNC_SYS_BEGIN = 3'd3,
    FUNC_SYS_END   = 3'd4
  } func_e;

  localparam logic [StatW-1:0] ST_FREE     = 2'd0;
  localparam logic [StatW-1:0] ST_RUNNABLE = 2'd1;
  localparam logic [StatW-1:0] ST_MAX      = 2'd2;

  localparam logic [ResW-1:0] RES_OK            = 3'd0;
  localparam logic [ResW-1:0] RES_NO_FREE       = 3'd1;
  localparam logic [ResW-1:0] RES_DEFERRED      = 3'd2;
  localparam logic [ResW-1:0] RES_NESTED        = 3'd3;
  localparam logic [ResW-1:0] RES_NONE_RUNNABLE = 3'd4;
  localparam logic [ResW-1:0] RES_QUEUE_FULL    = 3'd5;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [PidW-1:0]   target_pid;
    logic [StatW-1:0]  new_status;
    logic [LevelW-1:0] level;
  } req_t;

  typedef struct packed {
    logic [PidW-1:0] running_pid;
    logic [PidW-1:0] assigned_pid;
    logic [ResW-1:0] status;
    logic            reselected;
  } rsp_t;

endpackage

### hdl/mrrs_req_if.sv
`timescale 1ns / 1ps
interface mrrs_req_if;
  import mrrs_pkg::*;
  logic valid;
  logic ready;
  logic [FuncW-1:0]  func;
  logic [PidW-1:0]   target_pid;
  logic [StatW-1:0]  new_status;
  logic [LevelW-1:0] level;
  modport source (output valid, func, target_pid, new_status, level, input ready);
  modport sink (input valid, func, target_pid, new_status, level, output ready);
endinterface

### hdl/mrrs_rsp_if.sv
`timescale 1ns / 1ps
interface mrrs_rsp_if;
  import mrrs_pkg::*;
  logic valid;
  logic ready;
  logic [PidW-1:0] running_pid;
  logic [PidW-1:0] assigned_pid;
  logic [ResW-1:0] status;
  logic            reselected;
  modport source (output valid, running_pid, assigned_pid, status, reselected, input ready);
  modport sink (input valid, running_pid, assigned_pid, status, reselected, output ready);
endinterface

### hdl/mrrs_front.sv
`timescale 1ns / 1ps
// Capture transactions into a two-entry queue.
module mrrs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  mrrs_req_if.sink          req,
  output mrrs_pkg::req_t    q_data_o,
  output logic              q_valid_o,
  input  logic              q_pop_i
);
  import mrrs_pkg::*;

  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign req.ready = (cnt_q != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{func: req.func, target_pid: req.target_pid,
                       new_status: req.new_status, level: req.level};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

### hdl/mrrs_back.sv
`timescale 1ns / 1ps
// Execute one event at a time; a scan reads and rotates queue entries one by one, through S_RD then S_ROT.
module mrrs_back #(
  parameter int unsigned NUM_PROCS = 16,
  parameter int unsigned TOP_LEVEL = 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mrrs_pkg::req_t q_data_i,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  mrrs_rsp_if.source     rsp
);
  import mrrs_pkg::*;

  localparam int unsigned NumLevels = TOP_LEVEL + 1;
  localparam int unsigned IdxW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int unsigned CntW = $clog2(NUM_PROCS + 1);
  localparam int unsigned LvW  = (NumLevels > 1) ? $clog2(NumLevels) : 1;
  localparam int unsigned PidIW = (IdxW > PidW) ? IdxW : PidW;
  localparam int unsigned AddrW = LvW + IdxW;
  localparam int unsigned Depth = 1 << AddrW;

  typedef enum logic [2:0] {S_IDLE, S_FIND, S_RD, S_ROT, S_OUT} state_e;

  state_e             state_q;
  logic [PidIW-1:0]   mem_q [Depth];
  logic [PidIW-1:0]   rdata_q;
  logic [IdxW-1:0]    head_q [NumLevels];
  logic [CntW-1:0]    count_q [NumLevels];
  logic [StatW-1:0]   pstat_q [NUM_PROCS];
  logic [PidIW-1:0]   cur_q;
  logic               sys_q, tick_q;
  logic [LvW-1:0]     lv_q;
  logic [CntW-1:0]    left_q;
  logic [IdxW-1:0]    fidx_q;
  logic               fhit_q;
  rsp_t               out_q;
  logic               ovalid_q;

  logic [PidW-1:0]    cur_tr;
  logic               cur_run;
  logic [LevelW-1:0]  adm_lv_raw;
  logic [LvW-1:0]     adm_lv;
  logic [IdxW-1:0]    tail;
  logic [IdxW-1:0]    rtail;
  logic [IdxW-1:0]    hnext;
  logic               start;
  logic [ResW-1:0]    idle_status;
  logic               idle_scan;
  state_e             idle_next;

  assign cur_tr  = cur_q[PidW-1:0];
  assign cur_run = (pstat_q[cur_q[IdxW-1:0]] == ST_RUNNABLE) &&
                   ({{(32-PidIW){1'b0}}, cur_q} < NUM_PROCS);
  assign adm_lv_raw = q_data_i.level;
  assign adm_lv = ({{(32-LevelW){1'b0}}, adm_lv_raw} > TOP_LEVEL) ?
                  LvW'(TOP_LEVEL) : LvW'(adm_lv_raw);

  function automatic logic [IdxW-1:0] wrap(input logic [IdxW:0] v);
    logic [IdxW:0] n;
    n = (IdxW + 1)'(NUM_PROCS);
    return (v >= n) ? IdxW'(v - n) : v[IdxW-1:0];
  endfunction

  assign tail  = wrap({1'b0, head_q[adm_lv]} + (IdxW + 1)'(count_q[adm_lv]));
  assign rtail = wrap({1'b0, head_q[lv_q]} + (IdxW + 1)'(count_q[lv_q]));
  assign hnext = wrap({1'b0, head_q[lv_q]} + (IdxW + 1)'(1));

  // Classify the event at the queue head.
  always_comb begin
    idle_status = RES_OK;
    idle_scan   = 1'b0;
    idle_next   = S_OUT;
    case (q_data_i.func)
      FUNC_TICK: begin
        if (sys_q) idle_status = RES_DEFERRED;
        else idle_scan = 1'b1;
      end
      FUNC_ADMIT: idle_next = S_FIND;
      FUNC_SYS_BEGIN: begin
        if (sys_q) idle_status = RES_NESTED;
      end
      FUNC_SYS_END: begin
        if (sys_q && (tick_q || !cur_run)) idle_scan = 1'b1;
      end
      default: ;
    endcase
    if (idle_scan) idle_next = S_RD;
  end

  assign start   = (state_q == S_IDLE) && q_valid_i && !ovalid_q;
  assign q_pop_o = (state_q == S_OUT);
  assign rsp.valid        = ovalid_q;
  assign rsp.running_pid  = out_q.running_pid;
  assign rsp.assigned_pid = out_q.assigned_pid;
  assign rsp.status       = out_q.status;
  assign rsp.reselected   = out_q.reselected;

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) rdata_q <= mem_q[{lv_q, head_q[lv_q]}];
    if (state_q == S_ROT) mem_q[{lv_q, rtail}] <= rdata_q;
    else if (state_q == S_OUT && q_data_i.func == FUNC_ADMIT && fhit_q &&
             count_q[adm_lv] < CntW'(NUM_PROCS))
      mem_q[{adm_lv, tail}] <= PidIW'(fidx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cur_q    <= '0;
      sys_q    <= 1'b0;
      tick_q   <= 1'b0;
      ovalid_q <= 1'b0;
      out_q    <= '0;
      lv_q     <= '0;
      left_q   <= '0;
      fidx_q   <= '0;
      fhit_q   <= 1'b0;
      for (int i = 0; i < NumLevels; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
      for (int i = 0; i < NUM_PROCS; i++) pstat_q[i] <= ST_FREE;
    end else begin
      if (rsp.valid && rsp.ready) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            out_q <= '{running_pid: cur_tr, assigned_pid: '0,
                       status: idle_status, reselected: idle_scan};
            state_q <= idle_next;
            if (idle_scan) begin
              lv_q   <= LvW'(TOP_LEVEL);
              left_q <= count_q[LvW'(TOP_LEVEL)];
            end
            case (q_data_i.func)
              FUNC_TICK: begin
                if (sys_q) tick_q <= 1'b1;
              end
              FUNC_SET_STAT: begin
                if (q_data_i.new_status <= ST_MAX &&
                    {{(32-PidW){1'b0}}, q_data_i.target_pid} < NUM_PROCS)
                  pstat_q[IdxW'(q_data_i.target_pid)] <= q_data_i.new_status;
              end
              FUNC_ADMIT: begin
                fidx_q <= '0;
                fhit_q <= 1'b0;
                left_q <= CntW'(NUM_PROCS);
              end
              FUNC_SYS_BEGIN: begin
                if (!sys_q) sys_q <= 1'b1;
              end
              FUNC_SYS_END: begin
                if (sys_q) begin
                  sys_q <= 1'b0;
                  if (idle_scan) tick_q <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_FIND: begin
          // Search the lowest free id, one per cycle.
          if (pstat_q[fidx_q] == ST_FREE) begin
            fhit_q  <= 1'b1;
            state_q <= S_OUT;
          end else if (left_q == CntW'(1)) begin
            state_q <= S_OUT;
          end else begin
            fidx_q <= fidx_q + IdxW'(1);
            left_q <= left_q - CntW'(1);
          end
        end
        S_RD: begin
          if (left_q == '0) begin
            if (lv_q == '0) begin
              out_q.status <= RES_NONE_RUNNABLE;
              state_q <= S_OUT;
            end else begin
              lv_q   <= lv_q - LvW'(1);
              left_q <= count_q[lv_q - LvW'(1)];
            end
          end else begin
            state_q <= S_ROT;
          end
        end
        S_ROT: begin
          head_q[lv_q] <= hnext;
          left_q <= left_q - CntW'(1);
          if ({{(32-PidIW){1'b0}}, rdata_q} < NUM_PROCS &&
              pstat_q[rdata_q[IdxW-1:0]] == ST_RUNNABLE) begin
            cur_q <= rdata_q;
            out_q.running_pid <= rdata_q[PidW-1:0];
            state_q <= S_OUT;
          end else begin
            state_q <= S_RD;
          end
        end
        S_OUT: begin
          if (q_data_i.func == FUNC_ADMIT) begin
            if (!fhit_q) out_q.status <= RES_NO_FREE;
            else if (count_q[adm_lv] >= CntW'(NUM_PROCS)) out_q.status <= RES_QUEUE_FULL;
            else begin
              count_q[adm_lv] <= count_q[adm_lv] + CntW'(1);
              pstat_q[fidx_q] <= ST_RUNNABLE;
              out_q.assigned_pid <= PidW'(fidx_q);
            end
          end
          ovalid_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Pop happens on the last cycle so the queue head holds the request while working.
endmodule

### hdl/multilevel_round_robin_scheduler.sv
`timescale 1ns / 1ps
// Multilevel round-robin scheduler. Events enter on req, one result per event
// leaves on rsp. A front queue of two entries takes events while the back end
// works. A simple event goes from S_IDLE to S_OUT; an admit first probes ids in
// S_FIND for the lowest free id (up to NUM_PROCS); a scan reads and rotates
// queue entries through S_RD and S_ROT, and moves down past a level whose queue
// holds no runnable id.
// The queue store needs no clearing after reset.
module multilevel_round_robin_scheduler #(
  parameter int unsigned NUM_PROCS = 16,
  parameter int unsigned TOP_LEVEL = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrrs_req_if.sink   req,
  mrrs_rsp_if.source rsp
);
  import mrrs_pkg::*;

  req_t q_data;
  logic q_valid, q_pop;

  // Front: accept and hold transactions.
  mrrs_front u_front (
    .clk_i, .rst_ni, .req,
    .q_data_o (q_data), .q_valid_o (q_valid), .q_pop_i (q_pop)
  );

  // Back: execute the event and hold its result until taken.
  mrrs_back #(.NUM_PROCS(NUM_PROCS), .TOP_LEVEL(TOP_LEVEL)) u_back (
    .clk_i, .rst_ni,
    .q_data_i (q_data), .q_valid_i (q_valid), .q_pop_o (q_pop), .rsp
  );
endmodule

### hdl/mrrs_checker.sv
`timescale 1ns / 1ps
module mrrs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [mrrs_pkg::ResW-1:0] rsp_status,
  input logic [mrrs_pkg::PidW-1:0] rsp_assigned,
  input logic                      rsp_resel
);
  import mrrs_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
  a_asg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status != RES_OK |-> rsp_assigned == '0) else $error("bad assigned");
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status == RES_NONE_RUNNABLE |-> rsp_resel)
    else $error("none without scan");
  a_def: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status == RES_DEFERRED |-> !rsp_resel) else $error("deferred scan");
endmodule

bind multilevel_round_robin_scheduler mrrs_checker u_chk (
  .clk_i, .rst_ni, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.status), .rsp_assigned(rsp.assigned_pid),
  .rsp_resel(rsp.reselected)
);
